// ----- sv/tsc_pkg.sv -----
// Shared types and constants for the timestamp-counter to nanosecond time base.
// Used by tsc_div and tsc_to_nanosecond_time_base_top; no dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int DIV_W     = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic [31:0] STD_LEAF_MIN    = 32'h0000_0015;
    localparam logic [31:0] HV_LEAF_MIN     = 32'h4000_0010;
    localparam logic [63:0] DEFAULT_RATE_HZ = 64'd2500000000;
    localparam logic [31:0] NS_PER_SEC      = 32'd1000000000;

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTER_START     = 8'd0,
        REG_MAX_STANDARD_LEAF = 8'd1,
        REG_RATIO_DENOMINATOR = 8'd2,
        REG_RATIO_NUMERATOR   = 8'd3,
        REG_CRYSTAL_HZ        = 8'd4,
        REG_MAX_HV_LEAF       = 8'd5,
        REG_HYPERVISOR_KHZ    = 8'd6
    } cfg_index_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- sv/tsc_to_nanosecond_time_base_top.sv -----
// Top level of the timestamp-counter to nanosecond time base: sequencer,
// configuration registers, shared 32x32 multiplier. Depends on tsc_pkg, tsc_div.
`timescale 1ns / 1ps

// Each input word carries a 64-bit counter reading and returns one output word
// with nanoseconds since boot and wall-clock nanoseconds. The tick rate comes
// from the configuration registers (crystal times ratio, then the hypervisor
// kHz value, then 2.5 GHz) and is recomputed the first time a word arrives
// after a configuration write. The block takes one word at a time: a word
// occupies it from acceptance to the next tready for two dependent 64-step
// passes through the shared radix-2 divider (seconds and remainder, then the
// fractional nanoseconds) plus the multiply steps on the shared multiplier.
// The first word after a configuration write also takes one multiply and one
// more divider pass that rebuild the tick rate.
// A finished result sits in the output register while the next word is already
// accepted; only the final step waits for that register to drain.
module tsc_to_nanosecond_time_base_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [127:0]                      s_tdata,   // [63:0] counter_now, [127:64] host_wall_ns
    input  logic [0:0]                        s_tuser,   // [0] resync
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [127:0]                      m_tdata,   // [63:0] monotonic_ns, [127:64] wall_ns
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RMUL,
        ST_RMUL_W,
        ST_RDIV,
        ST_DSTART,
        ST_DDIV,
        ST_M_SLO,
        ST_M_SHI,
        ST_M_RLO,
        ST_M_RHI,
        ST_M_SUM,
        ST_FSTART,
        ST_FDIV,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [63:0] counter_start_reg;
    logic [31:0] max_std_leaf_reg;
    logic [31:0] ratio_den_reg;
    logic [31:0] ratio_num_reg;
    logic [31:0] crystal_hz_reg;
    logic [31:0] max_hv_leaf_reg;
    logic [31:0] hv_khz_reg;

    // Time base state.
    logic [63:0] rate_reg;
    logic        dirty_reg;
    logic [63:0] epoch_reg;

    // Per-word working registers.
    logic [63:0] d_reg;
    logic        resync_reg;
    logic [63:0] host_reg;
    logic [63:0] secs_reg;
    logic [63:0] rem_reg;
    logic [63:0] acc_reg;
    logic [63:0] tmp_reg;
    logic [63:0] frac_reg;
    logic [63:0] mul_reg;

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    // Shared multiplier operands and divider hookup.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [63:0] div_divisor;
    logic [63:0] div_quo;
    logic [63:0] div_rem;
    tsc_pkg::div_status_t div_stat;

    logic        std_ok;
    logic        hv_ok;
    logic [63:0] hv_khz_ext;
    logic [63:0] hv_rate;
    logic [63:0] mono_w;
    logic        out_free;
    logic        s_accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign std_ok = (max_std_leaf_reg >= tsc_pkg::STD_LEAF_MIN) && (ratio_den_reg != '0) &&
                    (ratio_num_reg != '0) && (crystal_hz_reg != '0);
    assign hv_ok  = (max_hv_leaf_reg >= tsc_pkg::HV_LEAF_MIN) && (hv_khz_reg != '0);

    // kHz to Hz: times 1000 as 1024 - 16 - 8.
    assign hv_khz_ext = {32'd0, hv_khz_reg};
    assign hv_rate    = (hv_khz_ext << 10) - (hv_khz_ext << 4) - (hv_khz_ext << 3);

    assign mono_w = acc_reg + frac_reg;

    always_comb begin
        mul_a = secs_reg[31:0];
        mul_b = tsc_pkg::NS_PER_SEC;
        unique case (state_reg)
            ST_RMUL: begin
                mul_a = crystal_hz_reg;
                mul_b = ratio_num_reg;
            end
            ST_M_SHI: mul_a = secs_reg[63:32];
            ST_M_RLO: mul_a = rem_reg[31:0];
            ST_M_RHI: mul_a = rem_reg[63:32];
            default:  mul_a = secs_reg[31:0];
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = d_reg;
        div_divisor  = rate_reg;
        unique case (state_reg)
            ST_RMUL_W: begin
                div_start    = 1'b1;
                div_dividend = mul_reg;
                div_divisor  = {32'd0, ratio_den_reg};
            end
            ST_DSTART: div_start = 1'b1;
            ST_FSTART: begin
                div_start    = 1'b1;
                div_dividend = tmp_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    tsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            counter_start_reg <= '0;
            max_std_leaf_reg  <= '0;
            ratio_den_reg     <= '0;
            ratio_num_reg     <= '0;
            crystal_hz_reg    <= '0;
            max_hv_leaf_reg   <= '0;
            hv_khz_reg        <= '0;
            rate_reg          <= tsc_pkg::DEFAULT_RATE_HZ;
            dirty_reg         <= 1'b0;
            epoch_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            mul_reg <= {32'd0, mul_a} * {32'd0, mul_b};

            if (cfg_valid && cfg_ready) begin
                dirty_reg <= 1'b1;
                unique case (cfg_index)
                    tsc_pkg::REG_COUNTER_START:     counter_start_reg <= cfg_data;
                    tsc_pkg::REG_MAX_STANDARD_LEAF: max_std_leaf_reg  <= cfg_data[31:0];
                    tsc_pkg::REG_RATIO_DENOMINATOR: ratio_den_reg     <= cfg_data[31:0];
                    tsc_pkg::REG_RATIO_NUMERATOR:   ratio_num_reg     <= cfg_data[31:0];
                    tsc_pkg::REG_CRYSTAL_HZ:        crystal_hz_reg    <= cfg_data[31:0];
                    tsc_pkg::REG_MAX_HV_LEAF:       max_hv_leaf_reg   <= cfg_data[31:0];
                    tsc_pkg::REG_HYPERVISOR_KHZ:    hv_khz_reg        <= cfg_data[31:0];
                    default:                        dirty_reg         <= dirty_reg;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        d_reg      <= s_tdata[63:0] - counter_start_reg;
                        host_reg   <= s_tdata[127:64];
                        resync_reg <= s_tuser[0];
                        state_reg  <= dirty_reg ? ST_RMUL : ST_DSTART;
                    end
                end
                ST_RMUL:   state_reg <= ST_RMUL_W;
                ST_RMUL_W: state_reg <= ST_RDIV;
                ST_RDIV: begin
                    if (div_stat.done) begin
                        // Fallback chain: crystal ratio, hypervisor rate, default.
                        priority if (std_ok && div_quo != '0) begin
                            rate_reg <= div_quo;
                        end else if (hv_ok) begin
                            rate_reg <= hv_rate;
                        end else begin
                            rate_reg <= tsc_pkg::DEFAULT_RATE_HZ;
                        end
                        dirty_reg <= 1'b0;
                        state_reg <= ST_DSTART;
                    end
                end
                ST_DSTART: state_reg <= ST_DDIV;
                ST_DDIV: begin
                    if (div_stat.done) begin
                        secs_reg  <= div_quo;
                        rem_reg   <= div_rem;
                        state_reg <= ST_M_SLO;
                    end
                end
                ST_M_SLO: state_reg <= ST_M_SHI;
                ST_M_SHI: begin
                    acc_reg   <= mul_reg;
                    state_reg <= ST_M_RLO;
                end
                ST_M_RLO: begin
                    // Only the low half of the upper partial product survives mod 2^64.
                    acc_reg   <= acc_reg + {mul_reg[31:0], 32'd0};
                    state_reg <= ST_M_RHI;
                end
                ST_M_RHI: begin
                    tmp_reg   <= mul_reg;
                    state_reg <= ST_M_SUM;
                end
                ST_M_SUM: begin
                    tmp_reg   <= tmp_reg + {mul_reg[31:0], 32'd0};
                    state_reg <= ST_FSTART;
                end
                ST_FSTART: state_reg <= ST_FDIV;
                ST_FDIV: begin
                    if (div_stat.done) begin
                        frac_reg  <= div_quo;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg       <= 1'b1;
                        m_tdata_reg[63:0]  <= mono_w;
                        if (resync_reg && host_reg != '0) begin
                            epoch_reg           <= host_reg - mono_w;
                            m_tdata_reg[127:64] <= host_reg;
                        end else begin
                            m_tdata_reg[127:64] <= epoch_reg + mono_w;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // An accepted word keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted again right after a word");

    // The sequencer never restarts the divider while it is still iterating.
    a_div_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // The tick rate used as divisor is never zero.
    a_rate_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DSTART || state_reg == ST_FSTART) |-> (rate_reg != '0))
        else $error("zero tick rate at divider start");

endmodule

// ----- sv/tsc_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on tsc_pkg for the operand width and the status struct.
`timescale 1ns / 1ps

module tsc_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tsc_pkg::DIV_W-1:0] dividend,
    input  logic [tsc_pkg::DIV_W-1:0] divisor,
    output logic [tsc_pkg::DIV_W-1:0] quotient,
    output logic [tsc_pkg::DIV_W-1:0] remainder,
    output tsc_pkg::div_status_t     status
);

    localparam int W     = tsc_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]   shifted;
    logic [W+1:0] diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // The partial remainder stays below the divisor, so it fits W bits.
                if (!diff[W+1]) begin
                    rem_reg <= diff[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
